// File: hw/rtl/rtt_gc_pkg.sv
// ----------------------------------------------------------------------------
// rtt_gc_pkg
// Shared widths, codes, types and helpers of the rtt gradient rate control.
// ----------------------------------------------------------------------------
package rtt_gc_pkg;

    // fixed field widths
    localparam int RATE_W  = 24;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // flow constants
    localparam int unsigned MIN_RTT   = 512;
    localparam int unsigned RATE_BITS = 24;

    // largest rate that RATE_BITS can hold, seen at the rate field width
    localparam logic [RATE_W-1:0] RATE_LIM = (RATE_BITS >= RATE_W) ? {RATE_W{1'b1}}
                                            : RATE_W'((64'd1 << RATE_BITS) - 64'd1);

    // Q16 one
    localparam logic [16:0] Q16_ONE = 17'h1_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 3'd5;

    // shared multiplier operand widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared divider
    localparam int DIV_N_W        = 48;
    localparam int DIV_D_W        = 32;
    localparam int DIV_FULL_STEPS = DIV_N_W;
    localparam int DIV_FAST_STEPS = DIV_N_W - DIV_D_W;
    localparam int DIV_CNT_W      = $clog2(DIV_FULL_STEPS + 1);

    // rate decision codes
    typedef enum logic [1:0] {
        DEC_LOW_ADD    = 2'd0,
        DEC_HIGH_SCALE = 2'd1,
        DEC_GRAD_ADD   = 2'd2,
        DEC_GRAD_DEC   = 2'd3
    } decision_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_D,
        ST_SUM,
        ST_DIV,
        ST_MUL_F,
        ST_MUL_G,
        ST_CHK_G,
        ST_MUL_R,
        ST_RES_MUL,
        ST_DONE
    } ctrl_state_t;

    // divider command and status
    typedef struct packed {
        logic start;
        logic fast;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // saturate a rate to max_rate and the RATE_BITS limit
    function automatic logic [RATE_W-1:0] rate_limit(input logic [32:0] r,
                                                     input logic [RATE_W-1:0] max_rate);
        logic [RATE_W-1:0] lim;
        lim = (max_rate < RATE_LIM) ? max_rate : RATE_LIM;
        return (r > 33'(lim)) ? lim : r[RATE_W-1:0];
    endfunction

endpackage

// File: hw/rtl/rtt_gc_mul.sv
// ----------------------------------------------------------------------------
// rtt_gc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rtt_gc_mul (
    input  logic                                clk,
    input  logic signed [rtt_gc_pkg::MUL_A_W-1:0] a,
    input  logic signed [rtt_gc_pkg::MUL_B_W-1:0] b,
    output logic signed [rtt_gc_pkg::MUL_P_W-1:0] p
);
    import rtt_gc_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    // product register, valid in the cycle after the operands
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/rtt_gc_div.sv
// ----------------------------------------------------------------------------
// rtt_gc_div
// Iterative restoring divider, one quotient bit per cycle. The fast mode
// starts with the upper dividend word as remainder when it is known to be
// below the divisor and runs only the low quotient bits.
// ----------------------------------------------------------------------------
module rtt_gc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtt_gc_pkg::div_cmd_t               cmd,
    input  logic [rtt_gc_pkg::DIV_N_W-1:0]     dividend,
    input  logic [rtt_gc_pkg::DIV_D_W-1:0]     divisor,
    output rtt_gc_pkg::div_stat_t              stat,
    output logic [rtt_gc_pkg::DIV_N_W-1:0]     quotient
);
    import rtt_gc_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_N_W-1:0]   work_reg;
    logic [DIV_N_W-1:0]   work_next;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W-1:0]   dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_D_W:0]     trial;

    // one restoring step
    assign trial = {rem_reg, work_reg[DIV_N_W-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            dsr_next = divisor;
            if (cmd.fast)
            begin
                rem_next  = dividend[DIV_N_W-1:DIV_FAST_STEPS];
                work_next = {dividend[DIV_FAST_STEPS-1:0], {DIV_D_W{1'b0}}};
                cnt_next  = DIV_CNT_W'(DIV_FAST_STEPS);
            end
            else
            begin
                rem_next  = '0;
                work_next = dividend;
                cnt_next  = DIV_CNT_W'(DIV_FULL_STEPS);
            end
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DIV_D_W])
            begin
                rem_next = trial[DIV_D_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[DIV_D_W-2:0], work_reg[DIV_N_W-1]};
            end
            work_next = {work_reg[DIV_N_W-2:0], ~trial[DIV_D_W]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = work_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("divider started while busy");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> ($past(stat.busy) && !stat.busy))
        else $error("divider done without a finished run");

endmodule

// File: hw/rtl/rtt_gradient_rate_control_core.sv
// ----------------------------------------------------------------------------
// rtt_gradient_rate_control_core
// Rate update from one acknowledgement item: rtt, smoothed rtt gradient and
// the new rate of the flow.
// ----------------------------------------------------------------------------
// One acknowledgement item at a time runs through a small sequencer around
// one shared registered multiplier and one shared bit-serial divider. The
// low-rtt and gradient-add decisions go from ST_SUM to ST_DONE, the
// multiplicative decrease passes ST_MUL_G, ST_CHK_G and, if the product fits,
// ST_MUL_R and ST_RES_MUL, and high-rtt scaling waits in ST_DIV (16 divider
// steps) before ST_MUL_F and ST_RES_MUL; the divider dominates. The result
// sits in an output register, so the next item is accepted while the
// previous result waits to be taken. There is no clearing pass after reset.
module rtt_gradient_rate_control_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // acknowledgement items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rtt_gc_pkg::TIME_W-1:0]        arrival_time,
    input  logic [rtt_gc_pkg::TIME_W-1:0]        send_time,
    input  logic [rtt_gc_pkg::RATE_W-1:0]        current_rate,
    // result items
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rtt_gc_pkg::RATE_W-1:0]        new_rate,
    output logic [rtt_gc_pkg::TIME_W-1:0]        measured_rtt,
    output logic [1:0]                           decision,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [rtt_gc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtt_gc_pkg::CFG_W-1:0]         cfg_wdata
);
    import rtt_gc_pkg::*;

    // configuration registers
    logic [16:0]       alpha_reg;
    logic [16:0]       beta_reg;
    logic [TIME_W-1:0] low_reg;
    logic [TIME_W-1:0] high_reg;
    logic [15:0]       add_reg;
    logic [RATE_W-1:0] max_reg;

    // sequencer and flow state
    ctrl_state_t              state_reg;
    ctrl_state_t              state_next;
    logic [TIME_W-1:0]        prev_rtt_reg;
    logic [TIME_W-1:0]        prev_rtt_next;
    logic signed [31:0]       s_reg;
    logic signed [31:0]       s_next;

    // item working registers
    logic [TIME_W-1:0]        rtt_reg;
    logic [TIME_W-1:0]        rtt_next;
    logic [RATE_W-1:0]        rate_reg;
    logic [RATE_W-1:0]        rate_next;
    logic signed [TIME_W:0]   diff_reg;
    logic signed [TIME_W:0]   diff_next;
    logic signed [35:0]       acc_reg;
    logic signed [35:0]       acc_next;
    decision_t                dec_reg;
    decision_t                dec_next;
    logic [RATE_W-1:0]        nr_reg;
    logic [RATE_W-1:0]        nr_next;
    logic [16:0]              om_reg;
    logic [16:0]              om_next;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [RATE_W-1:0]        new_rate_reg;
    logic [RATE_W-1:0]        new_rate_next;
    logic [TIME_W-1:0]        measured_rtt_reg;
    logic [TIME_W-1:0]        measured_rtt_next;
    decision_t                decision_reg;
    decision_t                decision_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;
    logic [DIV_N_W-1:0]        div_dividend;
    logic [DIV_D_W-1:0]        div_divisor;
    logic [DIV_N_W-1:0]        div_q;

    // helpers
    logic [16:0]        alpha_w;
    logic [16:0]        beta_w;
    logic signed [35:0] s_sum;
    logic signed [31:0] s_sat;
    logic [46:0]        g_full;
    logic [32:0]        g_clamp;
    logic               out_free;

    rtt_gc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    rtt_gc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // weights above one count as one
    assign alpha_w = (alpha_reg > Q16_ONE) ? Q16_ONE : alpha_reg;
    assign beta_w  = (beta_reg > Q16_ONE) ? Q16_ONE : beta_reg;

    // ewma sum, floors come from the arithmetic shift of the product
    assign s_sum = acc_reg + $signed(mul_p[MUL_P_W-1:16]);

    always_comb
    begin
        if (!s_sum[35] && (|s_sum[34:31]))
        begin
            s_sat = 32'sh7FFF_FFFF;
        end
        else if (s_sum[35] && !(&s_sum[34:31]))
        begin
            s_sat = 32'sh8000_0000;
        end
        else
        begin
            s_sat = s_sum[31:0];
        end
    end

    // gradient in Q16 from the positive smoothed difference, clamped to 2^32
    assign g_full  = {s_reg[30:0], 16'h0000} / 47'(MIN_RTT);
    assign g_clamp = (g_full > 47'h1_0000_0000) ? 33'h1_0000_0000 : g_full[32:0];

    assign out_free = !out_valid_reg || out_ready;

    // sequencer: next state, unit operands and register updates
    always_comb
    begin
        state_next        = state_reg;
        prev_rtt_next     = prev_rtt_reg;
        s_next            = s_reg;
        rtt_next          = rtt_reg;
        rate_next         = rate_reg;
        diff_next         = diff_reg;
        acc_next          = acc_reg;
        dec_next          = dec_reg;
        nr_next           = nr_reg;
        om_next           = om_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        new_rate_next     = new_rate_reg;
        measured_rtt_next = measured_rtt_reg;
        decision_next     = decision_reg;
        mul_a             = '0;
        mul_b             = '0;
        div_cmd           = '0;
        div_dividend      = '0;
        div_divisor       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rtt_next   = arrival_time - send_time;
                    rate_next  = current_rate & RATE_LIM;
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                // old smoothed difference times one minus alpha
                mul_a         = MUL_A_W'(s_reg);
                mul_b         = $signed({1'b0, Q16_ONE - alpha_w});
                diff_next     = $signed({1'b0, rtt_reg}) - $signed({1'b0, prev_rtt_reg});
                prev_rtt_next = rtt_reg;
                state_next    = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                // newest difference times alpha
                mul_a      = MUL_A_W'(diff_reg);
                mul_b      = $signed({1'b0, alpha_w});
                acc_next   = $signed(mul_p[MUL_P_W-1:16]);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                s_next = s_sat;
                if (rtt_reg < low_reg)
                begin
                    dec_next   = DEC_LOW_ADD;
                    nr_next    = rate_limit(33'(rate_reg) + 33'(add_reg), max_reg);
                    state_next = ST_DONE;
                end
                else if (rtt_reg > high_reg)
                begin
                    // high_threshold << 16 over rtt, upper word below rtt
                    dec_next     = DEC_HIGH_SCALE;
                    div_cmd      = '{start: 1'b1, fast: 1'b1};
                    div_dividend = {high_reg, 16'h0000};
                    div_divisor  = rtt_reg;
                    state_next   = ST_DIV;
                end
                else if (s_sat[31] || (s_sat == 32'sd0))
                begin
                    dec_next   = DEC_GRAD_ADD;
                    nr_next    = rate_limit(33'(rate_reg) + 33'({add_reg, 2'b00})
                                            + 33'(add_reg), max_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    // gradient taken from the updated smoothed difference
                    dec_next   = DEC_GRAD_DEC;
                    state_next = ST_MUL_G;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_F:
            begin
                // rate times the scale factor
                mul_a      = $signed({{(MUL_A_W-RATE_W){1'b0}}, rate_reg});
                mul_b      = $signed({2'b00, div_q[15:0]});
                state_next = ST_RES_MUL;
            end
            ST_MUL_G:
            begin
                // beta times gradient
                mul_a      = $signed({1'b0, g_clamp});
                mul_b      = $signed({1'b0, beta_w});
                state_next = ST_CHK_G;
            end
            ST_CHK_G:
            begin
                if (|mul_p[MUL_P_W-1:32])
                begin
                    nr_next    = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    om_next    = Q16_ONE - {1'b0, mul_p[31:16]};
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R:
            begin
                // rate times one minus beta times gradient
                mul_a      = $signed({{(MUL_A_W-RATE_W){1'b0}}, rate_reg});
                mul_b      = $signed({1'b0, om_reg});
                state_next = ST_RES_MUL;
            end
            ST_RES_MUL:
            begin
                nr_next    = rate_limit(mul_p[48:16], max_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    new_rate_next     = nr_reg;
                    measured_rtt_next = rtt_reg;
                    decision_next     = dec_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and flow state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_rtt_reg  <= 32'd1000;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_rtt_reg  <= prev_rtt_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        rtt_reg          <= rtt_next;
        rate_reg         <= rate_next;
        diff_reg         <= diff_next;
        acc_reg          <= acc_next;
        dec_reg          <= dec_next;
        nr_reg           <= nr_next;
        om_reg           <= om_next;
        new_rate_reg     <= new_rate_next;
        measured_rtt_reg <= measured_rtt_next;
        decision_reg     <= decision_next;
    end

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 17'd57344;
            beta_reg  <= 17'd52428;
            low_reg   <= 32'd600;
            high_reg  <= 32'd2000;
            add_reg   <= 16'd5;
            max_reg   <= 24'hFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA:    alpha_reg <= cfg_wdata[16:0];
                CFG_BETA:     beta_reg  <= cfg_wdata[16:0];
                CFG_LOW_THR:  low_reg   <= cfg_wdata;
                CFG_HIGH_THR: high_reg  <= cfg_wdata;
                CFG_ADD_STEP: add_reg   <= cfg_wdata[15:0];
                CFG_MAX_RATE: max_reg   <= cfg_wdata[RATE_W-1:0];
                default:      ;
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign new_rate     = new_rate_reg;
    assign measured_rtt = measured_rtt_reg;
    assign decision     = decision_reg;

    // checks
    a_div_only_scaling: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_stat.done) |-> (dec_reg == DEC_HIGH_SCALE))
        else $error("divider result on a path without division");

    a_rtt_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (measured_rtt_reg == prev_rtt_reg))
        else $error("previous rtt does not match the delivered rtt");

    a_rate_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (nr_reg <= max_reg))
        else $error("new rate above max_rate");

endmodule
